// ----- hdl/utf8sd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Shared types and constants for the UTF-8 stream decoder
// ----------------------------------------------------------------------------
package utf8sd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CP_W     = 21;
    localparam int unsigned CNT_W    = 16;
    localparam int unsigned LEFT_W   = 3;
    localparam int unsigned STATUS_W = 2;

    localparam logic [CNT_W-1:0] MAX_CHARS_RST = 16'hFFFF;

    // lead and trail byte payload masks
    localparam logic [BYTE_W-1:0] MASK_LEAD2  = 8'h1F;
    localparam logic [BYTE_W-1:0] MASK_LEAD3  = 8'h0F;
    localparam logic [BYTE_W-1:0] MASK_LEAD4  = 8'h07;
    localparam logic [BYTE_W-1:0] MASK_TRAIL  = 8'h3F;

    // last sequence position whose bits are still taken
    localparam logic [LEFT_W-1:0] LAST_ACC_POS = 3'd3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEAD = 2'd1,
        ST_CUT      = 2'd2
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        t_status          status;
        logic [CNT_W-1:0] char_index;
        logic             last;
    } t_result;

endpackage : utf8sd_pkg
`default_nettype wire

// ----- hdl/utf8_stream_decoder.sv -----
// path: an accepted byte is held in the input register, decoded, and its result held in the result register
// throughput: one byte per cycle, set by the single decode step between input and result
// registers; a downstream stall holds both registers in place
// reset: synchronous active-low i_rst_n clears sequence state and the result count
// and sets max_chars to 65535
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Lenient UTF-8 byte stream to code point decoder, at most one result per sequence
// ----------------------------------------------------------------------------
module utf8_stream_decoder
    import utf8sd_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [CNT_W-1:0]    i_cfg_wr_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [BYTE_W-1:0]   i_in_byte,
    input  wire logic                i_end_of_string,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [CP_W-1:0]          o_code_point,
    output logic [STATUS_W-1:0]      o_status,
    output logic [CNT_W-1:0]         o_char_index,
    output logic                     o_last
);

    t_in_item w_in_item;
    t_in_item w_item;
    logic     w_item_valid;
    logic     w_free;
    logic     w_step;
    logic     w_emit;
    t_result  w_result;
    t_result  w_out_result;

    assign w_in_item.in_byte       = i_in_byte;
    assign w_in_item.end_of_string = i_end_of_string;

    assign w_step = w_item_valid && w_free;

    utf8sd_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_item       (w_in_item),
        .i_take       (w_step),
        .o_item_valid (w_item_valid),
        .o_item       (w_item)
    );

    utf8sd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (w_step),
        .i_item        (w_item),
        .o_emit        (w_emit),
        .o_result      (w_result)
    );

    utf8sd_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_step && w_emit),
        .i_result    (w_result),
        .o_free      (w_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (w_out_result)
    );

    assign o_code_point = w_out_result.code_point;
    assign o_status     = w_out_result.status;
    assign o_char_index = w_out_result.char_index;
    assign o_last       = w_out_result.last;

endmodule : utf8_stream_decoder
`default_nettype wire

// ----- hdl/utf8sd_in_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8sd_in_stage
// Input register: holds one byte transfer until the decode step takes it
// ----------------------------------------------------------------------------
module utf8sd_in_stage
    import utf8sd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_item,
    input  wire logic     i_take,
    output logic          o_item_valid,
    output t_in_item      o_item
);

    logic     r_vld;
    t_in_item r_item;
    logic     w_load;

    assign o_in_stall   = r_vld && !i_take;
    assign w_load       = i_in_valid && !o_in_stall;
    assign o_item_valid = r_vld;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_load) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

endmodule : utf8sd_in_stage
`default_nettype wire

// ----- hdl/utf8sd_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8sd_core
// Sequence state, result numbering and the one-byte decode step
// ----------------------------------------------------------------------------
module utf8sd_core
    import utf8sd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [CNT_W-1:0]  i_cfg_wr_data,
    input  wire logic              i_step,
    input  wire t_in_item          i_item,
    output logic                   o_emit,
    output t_result                o_result
);

    logic [LEFT_W-1:0] r_bytes_left, n_bytes_left;
    logic [LEFT_W-1:0] r_seq_position, n_seq_position;
    logic [CP_W-1:0]   r_accumulator, n_accumulator;
    logic [CNT_W-1:0]  r_result_count, n_result_count;
    logic [CNT_W-1:0]  r_max_chars;

    logic [LEFT_W-1:0] w_len;
    logic [BYTE_W-1:0] w_lead_bits;
    logic              w_req;
    logic [CP_W-1:0]   w_cp;
    t_status           w_status;
    logic [BYTE_W-1:0] w_b;
    logic              w_eos;

    assign w_b   = i_item.in_byte;
    assign w_eos = i_item.end_of_string;

    // lead byte classification
    always_comb begin
        unique case (w_b) inside
            [8'h00:8'h7F]: begin w_len = 3'd1; w_lead_bits = w_b;              end
            [8'hC0:8'hDF]: begin w_len = 3'd2; w_lead_bits = w_b & MASK_LEAD2; end
            [8'hE0:8'hEF]: begin w_len = 3'd3; w_lead_bits = w_b & MASK_LEAD3; end
            [8'hF0:8'hF7]: begin w_len = 3'd4; w_lead_bits = w_b & MASK_LEAD4; end
            [8'hF8:8'hFB]: begin w_len = 3'd5; w_lead_bits = w_b & MASK_LEAD4; end
            [8'hFC:8'hFD]: begin w_len = 3'd6; w_lead_bits = w_b & MASK_LEAD4; end
            default:       begin w_len = 3'd0; w_lead_bits = '0;               end
        endcase
    end

    always_comb begin
        n_bytes_left   = r_bytes_left;
        n_seq_position = r_seq_position;
        n_accumulator  = r_accumulator;
        w_req          = 1'b0;
        w_cp           = '0;
        w_status       = ST_OK;

        if (r_bytes_left == '0) begin
            if (w_len == 3'd0) begin
                w_req         = 1'b1;
                w_status      = ST_BAD_LEAD;
                n_accumulator = '0;
            end else if (w_len == 3'd1) begin
                w_req         = 1'b1;
                w_cp          = {{(CP_W-BYTE_W){1'b0}}, w_lead_bits};
                n_accumulator = '0;
            end else begin
                n_bytes_left   = w_len - 3'd1;
                n_seq_position = 3'd1;
                n_accumulator  = {{(CP_W-BYTE_W){1'b0}}, w_lead_bits};
            end
        end else begin
            if (r_seq_position <= LAST_ACC_POS) begin
                n_accumulator = {r_accumulator[CP_W-7:0], w_b[5:0]};
            end
            n_seq_position = r_seq_position + 3'd1;
            n_bytes_left   = r_bytes_left - 3'd1;
            if (n_bytes_left == '0) begin
                w_req          = 1'b1;
                w_cp           = n_accumulator;
                n_accumulator  = '0;
                n_seq_position = '0;
            end
        end

        // string ends inside a sequence
        if (w_eos && n_bytes_left != '0) begin
            w_req    = 1'b1;
            w_cp     = '0;
            w_status = ST_CUT;
        end

        o_emit              = w_req && (r_result_count < r_max_chars);
        o_result.code_point = w_cp;
        o_result.status     = w_status;
        o_result.char_index = r_result_count;
        o_result.last       = w_eos;

        n_result_count = r_result_count + {{(CNT_W-1){1'b0}}, o_emit};

        if (w_eos) begin
            n_bytes_left   = '0;
            n_seq_position = '0;
            n_accumulator  = '0;
            n_result_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left   <= '0;
            r_seq_position <= '0;
            r_accumulator  <= '0;
            r_result_count <= '0;
        end else if (i_step) begin
            r_bytes_left   <= n_bytes_left;
            r_seq_position <= n_seq_position;
            r_accumulator  <= n_accumulator;
            r_result_count <= n_result_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_chars <= MAX_CHARS_RST;
        end else if (i_cfg_wr_en) begin
            r_max_chars <= i_cfg_wr_data;
        end
    end

endmodule : utf8sd_core
`default_nettype wire

// ----- hdl/utf8sd_out_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8sd_out_stage
// Result register: holds one result until the downstream transfer completes
// ----------------------------------------------------------------------------
module utf8sd_out_stage
    import utf8sd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    output logic         o_free,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_result      o_result
);

    logic    r_vld;
    t_result r_result;

    assign o_free      = !r_vld || !i_out_stall;
    assign o_out_valid = r_vld;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_free) begin
            r_vld <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule : utf8sd_out_stage
`default_nettype wire
